/* design/ptx_pkg.sv */
// ----------------------------------------------------------------------------
// ptx_pkg: shared types and constants of the primaries-to-XYZ matrix unit.
// Widths of the determinant, numerator and quotient datapaths.
// ----------------------------------------------------------------------------
package ptx_pkg;

  localparam int unsigned InW   = 16;
  localparam int unsigned OutW  = 24;
  localparam int unsigned DetW  = 51;  // signed 3x3 determinant of 16-bit codes
  localparam int unsigned QW    = 25;  // quotient bits kept before saturation
  localparam int unsigned NumW  = 16 + 50 + 24 + 2;  // p * |Di| << frac, doubled

  typedef struct packed {
    logic                  ok;
    logic [8:0]            neg;
    logic [DetW-1:0]       dmag;  // magnitude of the determinant |D|
    logic [15:0]           wy;
  } ptx_ctl_t;

endpackage

/* design/ptx_div_cell.sv */
// ----------------------------------------------------------------------------
// ptx_div_cell: one restoring division step for nine lanes.
// Each cell retires one quotient bit per lane and hands its state on.
// ----------------------------------------------------------------------------
module ptx_div_cell
  import ptx_pkg::*;
#(
  parameter int unsigned DenW = 68
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [8:0][NumW-1:0]      rem_i,
  input  logic [8:0][QW-1:0]        quo_i,
  input  logic [8:0]                big_i,
  input  logic [DenW-1:0]           den_i,
  input  logic [NumW-1:0]           den_sh_i,
  output logic [8:0][NumW-1:0]      rem_o,
  output logic [8:0][QW-1:0]        quo_o,
  output logic [8:0]                big_o,
  output logic [DenW-1:0]           den_o
);
  logic [8:0][NumW-1:0] rem_d;
  logic [8:0][QW-1:0]   quo_d;

  always_comb begin
    for (int l = 0; l < 9; l++) begin
      if (rem_i[l] >= den_sh_i) begin
        rem_d[l] = rem_i[l] - den_sh_i;
        quo_d[l] = {quo_i[l][QW-2:0], 1'b1};
      end else begin
        rem_d[l] = rem_i[l];
        quo_d[l] = {quo_i[l][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      quo_o <= quo_d;
      big_o <= big_i;
      den_o <= den_i;
    end
  end
endmodule

/* design/primaries_to_xyz_matrix_unit.sv */
// ----------------------------------------------------------------------------
// primaries_to_xyz_matrix_unit: RGB-to-XYZ matrix from primaries and white.
// Throughput one transaction per cycle.
// The pipeline stalls as a whole when the output is held; reset clears all
// valid bits asynchronously, payload registers are not reset.
// Latency is six capture and arithmetic stages plus the chain of QW division cells,
// one quotient bit each.
// ----------------------------------------------------------------------------
module primaries_to_xyz_matrix_unit
  import ptx_pkg::*;
#(
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // red_x, red_y, red_z, green_x..z, blue_x..z, white_x..z (16 bits each)
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m_xr, m_xg, m_xb, m_yr, m_yg, m_yb, m_zr, m_zg, m_zb (24 bits), solve_ok
  output logic [223:0] m_axis_tdata
);
  localparam int unsigned DenW = DetW + 17;
  localparam int unsigned Lat  = 6 + QW;
  // Remainder width; NumW already covers the largest fraction shift.
  localparam int unsigned RW   = NumW;

  // Whole-pipeline enable: advance when the output slot is free or taken.
  logic adv;
  logic [Lat-1:0] vld_q;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: capture the primaries and the white point.
  logic [2:0][2:0][InW-1:0] p_q;
  logic [2:0][InW-1:0]      w_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) p_q[r][c] <= s_axis_tdata[(c*3+r)*16 +: 16];
        w_q[r] <= s_axis_tdata[(9+r)*16 +: 16];
      end
    end
  end

  // Stage 2: cofactors of P (each a difference of two 32-bit products).
  // Di = sum over rows of w[r] * cof[r][i]; D = sum of p[r][0] * cof[r][0].
  logic signed [33:0] cof_q [3][3];
  logic [2:0][2:0][InW-1:0] p2_q;
  logic [2:0][InW-1:0]      w2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          cof_q[r][c] <=
              $signed({2'b0, 32'(p_q[(r+1)%3][(c+1)%3] * p_q[(r+2)%3][(c+2)%3])})
            - $signed({2'b0, 32'(p_q[(r+1)%3][(c+2)%3] * p_q[(r+2)%3][(c+1)%3])});
        end
      end
      p2_q <= p_q;
      w2_q <= w_q;
    end
  end

  // Stage 3: determinants as sums of three 16x34 products.
  logic signed [DetW-1:0] d_q, di_q [3];
  logic [2:0][2:0][InW-1:0] p3_q;
  logic [InW-1:0] wy3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q <= DetW'($signed({1'b0, p2_q[0][0]}) * cof_q[0][0]
                 + $signed({1'b0, p2_q[1][0]}) * cof_q[1][0]
                 + $signed({1'b0, p2_q[2][0]}) * cof_q[2][0]);
      for (int i = 0; i < 3; i++) begin
        di_q[i] <= DetW'($signed({1'b0, w2_q[0]}) * cof_q[0][i]
                       + $signed({1'b0, w2_q[1]}) * cof_q[1][i]
                       + $signed({1'b0, w2_q[2]}) * cof_q[2][i]);
      end
      p3_q  <= p2_q;
      wy3_q <= w2_q[1];
    end
  end

  // Stage 4: magnitudes, signs, and the ok decision.
  logic [DetW-1:0] dm4_q, dim4_q [3];
  logic [8:0] neg4_q;
  logic ok4_q;
  logic [2:0][2:0][InW-1:0] p4_q;
  logic [InW-1:0] wy4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dm4_q <= d_q[DetW-1] ? DetW'(-d_q) : DetW'(d_q);
      for (int i = 0; i < 3; i++) begin
        dim4_q[i] <= di_q[i][DetW-1] ? DetW'(-di_q[i]) : DetW'(di_q[i]);
        for (int r = 0; r < 3; r++) neg4_q[r*3+i] <= di_q[i][DetW-1] ^ d_q[DetW-1];
      end
      ok4_q <= (wy3_q != '0) && (d_q != '0);
      p4_q  <= p3_q;
      wy4_q <= wy3_q;
    end
  end

  // Stage 5: numerators p*|Di| and denominator |D|*wy, each a 16 x 51 multiply.
  logic [8:0][66:0] num5_q;
  logic [DenW-1:0]  den5_q;
  logic [8:0] neg5_q;
  logic ok5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) num5_q[r*3+c] <= 67'(p4_q[r][c] * dim4_q[c]);
      den5_q <= DenW'(dm4_q * wy4_q);
      neg5_q <= neg4_q;
      ok5_q  <= ok4_q;
    end
  end

  // Stage 6: rounded dividend 2*n*2^F + den, compared against 2*den*2^k.
  logic [8:0][RW-1:0] rem6_q;
  logic [DenW-1:0] den6_q;
  logic [8:0] neg6_q;
  logic ok6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 9; l++)
        rem6_q[l] <= ({(RW-67)'(0), num5_q[l]} << (OUT_FRAC_BITS + 1))
                   + RW'(den5_q);
      den6_q <= den5_q;
      neg6_q <= neg5_q;
      ok6_q  <= ok5_q;
    end
  end

  // Division chain: cell k tests bit QW-1-k of the quotient. Bits QW and up
  // are saturation; an overflow compare at the chain's entry detects them.
  logic [QW:0][8:0][RW-1:0] rem_c;
  logic [QW:0][8:0][QW-1:0] quo_c;
  logic [QW:0][DenW-1:0]    den_c;
  logic [QW:0][8:0]         neg_c;
  logic [QW:0]              ok_c;
  logic [QW:0][8:0]         ovf_c;
  logic [8:0]               ovf;

  always_comb begin
    for (int l = 0; l < 9; l++)
      ovf[l] = (rem6_q[l] >> QW) >= ({(RW-DenW)'(0), den6_q} << 1);
  end
  assign rem_c[0] = rem6_q;
  assign quo_c[0] = '0;
  assign den_c[0] = den6_q;
  assign neg_c[0] = neg6_q;
  assign ok_c[0]  = ok6_q;
  assign ovf_c[0] = ovf;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    logic [RW-1:0] dsh;
    logic [8:0]    nb;
    logic          ok_q;
    logic [8:0]    ovf_q;
    logic [8:0][RW-1:0] ri;
    logic [8:0][RW-1:0] ro;
    assign dsh = {(RW-DenW)'(0), den_c[k]} << (QW - k);
    for (genvar l = 0; l < 9; l++) begin : g_l
      assign ri[l] = rem_c[k][l];
      assign rem_c[k+1][l] = ro[l];
    end
    ptx_div_cell #(.DenW(DenW)) u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .rem_i   (ri),
      .quo_i   (quo_c[k]),
      .big_i   (neg_c[k]),
      .den_i   (den_c[k]),
      .den_sh_i(dsh),
      .rem_o   (ro),
      .quo_o   (quo_c[k+1]),
      .big_o   (nb),
      .den_o   (den_c[k+1])
    );
    assign neg_c[k+1] = nb;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ok_q  <= ok_c[k];
        ovf_q <= ovf_c[k];
      end
    end
    assign ok_c[k+1]  = ok_q;
    assign ovf_c[k+1] = ovf_q;
  end

  // Output: saturate, apply sign, zero on failure.
  logic [8:0][OutW-1:0] code;
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      logic [QW-1:0] q;
      logic [OutW:0] mag;
      q = quo_c[QW][l];
      if (!neg_c[QW][l]) begin
        mag = (ovf_c[QW][l] || q > QW'(24'h7FFFFF)) ? 25'h7FFFFF : 25'(q);
      end else begin
        mag = (ovf_c[QW][l] || q > QW'(25'h800000)) ? 25'h800000 : 25'(q);
      end
      code[l] = ok_c[QW] ? (neg_c[QW][l] ? OutW'(-mag) : OutW'(mag)) : '0;
    end
  end
  assign m_axis_tdata = {7'b0, ok_c[QW], code};
endmodule
